// ===== design/mlfq_pkg.sv =====
`timescale 1ns / 1ps
// Shared constants and types of the multilevel feedback queue scheduler.
package mlfq_pkg;

  localparam int NUM_LEVELS     = 5;
  localparam int QUEUE_DEPTH    = 16;
  localparam int THREAD_ID_BITS = 6;

  localparam int LVL_W   = 3;
  localparam int HEAD_W  = $clog2(QUEUE_DEPTH);
  localparam int CNT_W   = $clog2(QUEUE_DEPTH + 1);
  localparam int ADDR_W  = $clog2(NUM_LEVELS * QUEUE_DEPTH);
  localparam int SLOTS   = NUM_LEVELS * QUEUE_DEPTH;
  localparam int QL_W    = 18;
  localparam int QMAX    = 131071;
  localparam int QSH_SAT = 17;
  localparam int SH_W    = 6;

  localparam int REQ_W  = 2;
  localparam int QBS_W  = 4;
  localparam int BLS_W  = 3;
  localparam int CIDX_W = 1;

  localparam logic [REQ_W-1:0] REQ_READY = 2'd0;
  localparam logic [REQ_W-1:0] REQ_PICK  = 2'd1;
  localparam logic [REQ_W-1:0] REQ_TICK  = 2'd2;

  localparam logic [CIDX_W-1:0] CFG_QUANTUM_BASE_SHIFT = 1'd0;
  localparam logic [CIDX_W-1:0] CFG_BOTTOM_LEVEL_SHIFT = 1'd1;

  typedef logic [LVL_W-1:0]          level_t;
  typedef logic [HEAD_W-1:0]         head_t;
  typedef logic [CNT_W-1:0]          count_t;
  typedef logic [ADDR_W-1:0]         addr_t;
  typedef logic [THREAD_ID_BITS-1:0] tid_t;
  typedef logic signed [QL_W-1:0]    quantum_t;

endpackage

// ===== design/multilevel_feedback_scheduler_core.sv =====
`timescale 1ns / 1ps
// Multilevel feedback queue scheduler core: ready queues, pick, quantum timer.
//
// Each request produces exactly one response. A request is registered on
// acceptance together with the queue memory read for a possible pick (the
// head of the highest non-empty level, with the state already updated by the
// request ahead of it), executed once the output register can take it, and
// placed there. Throughput is one request per cycle while the output is not
// stalled; the registered read of the 80-entry queue memory sets the
// pipeline depth. Configuration writes are always ready and take effect on
// the next executed request. The queue memory needs no clearing after reset.
module multilevel_feedback_scheduler_core (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [mlfq_pkg::CIDX_W-1:0]         cfg_index,
  input  logic [mlfq_pkg::QBS_W-1:0]          cfg_data,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [mlfq_pkg::REQ_W-1:0]          req_type,
  input  logic [mlfq_pkg::THREAD_ID_BITS-1:0] thread_id,
  input  logic [2:0]                          priority_req,
  input  logic                                cpu_idle,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [mlfq_pkg::THREAD_ID_BITS-1:0] picked_thread,
  output logic                                picked_valid,
  output logic                                preempt_request,
  output logic                                yield_request,
  output logic [2:0]                          current_level,
  output logic                                queue_full_drop
);

  localparam mlfq_pkg::level_t BOTTOM = mlfq_pkg::LVL_W'(mlfq_pkg::NUM_LEVELS - 1);

  // configuration
  logic [mlfq_pkg::QBS_W-1:0] quantum_base_shift;
  logic [mlfq_pkg::BLS_W-1:0] bottom_level_shift;

  // scheduler state
  mlfq_pkg::head_t    queue_head [mlfq_pkg::NUM_LEVELS];
  mlfq_pkg::count_t   queue_count [mlfq_pkg::NUM_LEVELS];
  mlfq_pkg::tid_t     running_thread;
  mlfq_pkg::level_t   running_level;
  mlfq_pkg::tid_t     last_seen_thread;
  logic               last_seen_valid;
  mlfq_pkg::quantum_t quantum_left;

  mlfq_pkg::head_t    queue_head_next [mlfq_pkg::NUM_LEVELS];
  mlfq_pkg::count_t   queue_count_next [mlfq_pkg::NUM_LEVELS];
  mlfq_pkg::tid_t     running_thread_next;
  mlfq_pkg::level_t   running_level_next;
  mlfq_pkg::tid_t     last_seen_thread_next;
  logic               last_seen_valid_next;
  mlfq_pkg::quantum_t quantum_left_next;

  // queue memory
  mlfq_pkg::tid_t ready_queue_store [mlfq_pkg::SLOTS];

  // execute stage
  logic                       st_valid;
  logic [mlfq_pkg::REQ_W-1:0] st_req;
  mlfq_pkg::tid_t             st_tid;
  logic [2:0]                 st_prio;
  logic                       st_idle;
  mlfq_pkg::tid_t             st_rd_data;
  logic                       st_byp;
  mlfq_pkg::tid_t             st_byp_data;

  logic st_fire;
  logic in_fire;
  logic do_op;

  mlfq_pkg::level_t rdy_lv;
  logic             rdy_full;
  logic             wr_en;
  mlfq_pkg::addr_t  wr_addr;
  mlfq_pkg::head_t  wr_slot;
  logic             pick_found;
  mlfq_pkg::level_t pick_lv;
  mlfq_pkg::tid_t   head_data;
  logic             nxt_found;
  mlfq_pkg::level_t nxt_lv;
  mlfq_pkg::addr_t  rd_addr;

  mlfq_pkg::tid_t   res_picked;
  logic             res_pvalid;
  logic             res_preempt;
  logic             res_yield;
  logic             res_drop;

  mlfq_pkg::quantum_t q_base;
  mlfq_pkg::quantum_t q_dec;

  function automatic logic [mlfq_pkg::LVL_W:0] first_nonempty(
    input mlfq_pkg::count_t cnt [mlfq_pkg::NUM_LEVELS]
  );
    logic [mlfq_pkg::LVL_W:0] r;
    r = '0;
    for (int i = mlfq_pkg::NUM_LEVELS - 1; i >= 0; i--) begin
      if (cnt[i] != '0) begin
        r = {1'b1, mlfq_pkg::LVL_W'(i)};
      end
    end
    return r;
  endfunction

  function automatic mlfq_pkg::head_t slot_wrap(input logic [mlfq_pkg::CNT_W:0] s);
    logic [mlfq_pkg::CNT_W:0] r;
    r = s;
    if (s >= (mlfq_pkg::CNT_W + 1)'(mlfq_pkg::QUEUE_DEPTH)) begin
      r = s - (mlfq_pkg::CNT_W + 1)'(mlfq_pkg::QUEUE_DEPTH);
    end
    return r[mlfq_pkg::HEAD_W-1:0];
  endfunction

  function automatic mlfq_pkg::addr_t slot_addr(input mlfq_pkg::level_t lv,
                                                input mlfq_pkg::head_t slot);
    return mlfq_pkg::ADDR_W'(int'(lv) * mlfq_pkg::QUEUE_DEPTH + int'(slot));
  endfunction

  function automatic mlfq_pkg::quantum_t quantum_for(
    input mlfq_pkg::level_t lv,
    input logic [mlfq_pkg::QBS_W-1:0] base,
    input logic [mlfq_pkg::BLS_W-1:0] bottom
  );
    logic [mlfq_pkg::SH_W-1:0] sh;
    mlfq_pkg::quantum_t q;
    sh = mlfq_pkg::SH_W'(lv) + mlfq_pkg::SH_W'(base);
    if (lv == BOTTOM) begin
      sh = sh + mlfq_pkg::SH_W'(bottom);
    end
    if (sh >= mlfq_pkg::SH_W'(mlfq_pkg::QSH_SAT)) begin
      q = mlfq_pkg::QL_W'(mlfq_pkg::QMAX);
    end else begin
      q = mlfq_pkg::quantum_t'(1) << sh;
    end
    return q;
  endfunction

  function automatic mlfq_pkg::level_t priority_lim(input logic [2:0] p);
    mlfq_pkg::level_t r;
    r = mlfq_pkg::LVL_W'(p);
    if (int'(p) > mlfq_pkg::NUM_LEVELS - 1) begin
      r = BOTTOM;
    end
    return r;
  endfunction

  assign cfg_ready = 1'b1;
  assign st_fire   = st_valid && (!out_valid || out_ready);
  assign in_ready  = !st_valid || st_fire;
  assign in_fire   = in_valid && in_ready;
  assign do_op     = st_fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      quantum_base_shift <= mlfq_pkg::QBS_W'(2);
      bottom_level_shift <= mlfq_pkg::BLS_W'(2);
    end else if (cfg_valid) begin
      case (cfg_index)
        mlfq_pkg::CFG_QUANTUM_BASE_SHIFT: quantum_base_shift <= cfg_data;
        mlfq_pkg::CFG_BOTTOM_LEVEL_SHIFT: bottom_level_shift <= cfg_data[mlfq_pkg::BLS_W-1:0];
        default: ;
      endcase
    end
  end

  // execute the staged request
  always_comb begin
    logic [mlfq_pkg::LVL_W:0] enc;
    rdy_lv = (priority_lim(st_prio));
    rdy_full = (queue_count[rdy_lv] >= mlfq_pkg::CNT_W'(mlfq_pkg::QUEUE_DEPTH));
    wr_slot = slot_wrap((mlfq_pkg::CNT_W + 1)'(queue_head[rdy_lv])
                        + (mlfq_pkg::CNT_W + 1)'(queue_count[rdy_lv]));
    wr_addr = slot_addr(rdy_lv, wr_slot);
    wr_en = do_op && (st_req == mlfq_pkg::REQ_READY) && !rdy_full;

    enc = first_nonempty(queue_count);
    pick_found = enc[mlfq_pkg::LVL_W];
    pick_lv = enc[mlfq_pkg::LVL_W-1:0];
    head_data = st_byp ? st_byp_data : st_rd_data;

    queue_head_next = queue_head;
    queue_count_next = queue_count;
    running_thread_next = running_thread;
    running_level_next = running_level;
    last_seen_thread_next = last_seen_thread;
    last_seen_valid_next = last_seen_valid;
    quantum_left_next = quantum_left;
    res_picked = '0;
    res_pvalid = 1'b0;
    res_preempt = 1'b0;
    res_yield = 1'b0;
    res_drop = 1'b0;
    q_base = quantum_left;
    q_dec = quantum_left;

    if (do_op) begin
      case (st_req)
        mlfq_pkg::REQ_READY: begin
          if (rdy_full) begin
            res_drop = 1'b1;
          end else begin
            queue_count_next[rdy_lv] = queue_count[rdy_lv] + 1'b1;
            res_preempt = (st_tid != running_thread) && (rdy_lv < running_level);
          end
        end
        mlfq_pkg::REQ_PICK: begin
          if (pick_found) begin
            res_picked = head_data;
            res_pvalid = 1'b1;
            queue_head_next[pick_lv] = slot_wrap((mlfq_pkg::CNT_W + 1)'(queue_head[pick_lv])
                                                 + (mlfq_pkg::CNT_W + 1)'(1));
            queue_count_next[pick_lv] = queue_count[pick_lv] - 1'b1;
            running_thread_next = head_data;
            running_level_next = pick_lv;
          end
        end
        mlfq_pkg::REQ_TICK: begin
          if (!st_idle) begin
            if (!last_seen_valid || last_seen_thread != running_thread) begin
              q_base = quantum_for(running_level, quantum_base_shift, bottom_level_shift);
              last_seen_thread_next = running_thread;
              last_seen_valid_next = 1'b1;
            end
            q_dec = q_base - mlfq_pkg::quantum_t'(1);
            quantum_left_next = q_dec;
            if (q_dec < 0) begin
              quantum_left_next = -mlfq_pkg::quantum_t'(1);
              if (running_level < BOTTOM) begin
                running_level_next = running_level + 1'b1;
              end
              res_yield = 1'b1;
            end
          end
        end
        default: ;
      endcase
    end

    // head of the highest non-empty level once this request has executed
    enc = first_nonempty(queue_count_next);
    nxt_found = enc[mlfq_pkg::LVL_W];
    nxt_lv = nxt_found ? enc[mlfq_pkg::LVL_W-1:0] : '0;
    rd_addr = slot_addr(nxt_lv, queue_head_next[nxt_lv]);
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      ready_queue_store[wr_addr] <= st_tid;
    end
    if (in_fire) begin
      st_rd_data <= ready_queue_store[rd_addr];
      st_byp <= wr_en && (wr_addr == rd_addr);
      st_byp_data <= st_tid;
      st_req <= req_type;
      st_tid <= thread_id;
      st_prio <= priority_req;
      st_idle <= cpu_idle;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st_valid <= 1'b0;
    end else if (in_ready) begin
      st_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < mlfq_pkg::NUM_LEVELS; i++) begin
        queue_head[i] <= '0;
        queue_count[i] <= '0;
      end
      running_thread <= '0;
      running_level <= '0;
      last_seen_thread <= '0;
      last_seen_valid <= 1'b0;
      quantum_left <= '0;
    end else begin
      queue_head <= queue_head_next;
      queue_count <= queue_count_next;
      running_thread <= running_thread_next;
      running_level <= running_level_next;
      last_seen_thread <= last_seen_thread_next;
      last_seen_valid <= last_seen_valid_next;
      quantum_left <= quantum_left_next;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (st_fire) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (st_fire) begin
      picked_thread <= res_picked;
      picked_valid <= res_pvalid;
      preempt_request <= res_preempt;
      yield_request <= res_yield;
      current_level <= 3'(running_level_next);
      queue_full_drop <= res_drop;
    end
  end

endmodule
